### hdl/pctb_pkg.sv
// ----------------------------------------------------------------------------
// pctb_pkg
// Shared types and constants for the prescaled countdown timer bank.
// ----------------------------------------------------------------------------
package pctb_pkg;

	localparam int STORE_ENTRIES_DEF = 256;

	localparam logic [7:0] PRESCALE_RELOAD = 8'd9;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PRESCALER_INDEX = 2'd0;
	localparam logic [1:0] CFG_FAST_RANGE_LAST = 2'd1;
	localparam logic [1:0] CFG_SLOW_RANGE_LAST = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] entry_index;
		logic [7:0] write_value;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       prescaler_wrapped;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] prescaler_index;
		logic [7:0] fast_range_last;
		logic [7:0] slow_range_last;
	} cfg_t;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic      valid;
		rsp_item_t item;
	} done_t;

endpackage

### hdl/pctb_ram.sv
// ----------------------------------------------------------------------------
// pctb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/pctb_ctrl.sv
// ----------------------------------------------------------------------------
// pctb_ctrl
// Request sequencer: clearing pass after reset, single-entry reads and
// writes, and the read-modify-write sweep that applies a tick to the store.
// ----------------------------------------------------------------------------
module pctb_ctrl import pctb_pkg::*; #(
	parameter int STORE_ENTRIES = STORE_ENTRIES_DEF,
	localparam int AW = $clog2(STORE_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          req_valid,
	output logic          req_stall,
	input  req_item_t     req,
	output done_t         done,
	input  logic          out_free,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input  logic [7:0]    ram_rdata
);

	// ranges only reach entry 255, so the sweep stops there
	localparam int SWEEP_LAST_I = (STORE_ENTRIES - 1 < 255) ? STORE_ENTRIES - 1 : 255;
	localparam logic [AW-1:0] SWEEP_LAST = AW'(SWEEP_LAST_I);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(STORE_ENTRIES - 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_PRE   = 7'b0001000,
		ST_SWEEP = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] idx_s1;
	logic          vld_s1;
	logic [7:0]    pre_q;
	logic          wrap_q;
	logic          in_store_q;
	rsp_item_t     res_q;

	logic       accept;
	logic       req_in_store;
	logic       pre_present;
	logic [7:0] pre_val;
	logic [8:0] sw_idx;
	logic [8:0] pre_idx;
	logic [8:0] fast_last;
	logic [8:0] slow_last;
	logic       is_pre;
	logic       in_fast;
	logic       step_slow;
	logic [7:0] new_val;

	assign req_stall    = (state_q != ST_IDLE);
	assign accept       = req_valid && !req_stall;
	assign req_in_store = 32'(req.entry_index) < STORE_ENTRIES;
	assign pre_present  = 32'(cfg.prescaler_index) < STORE_ENTRIES;
	assign pre_val      = pre_present ? ram_rdata : 8'd0;

	// entry update for the sweep stage
	assign sw_idx    = 9'(idx_s1);
	assign pre_idx   = {1'b0, cfg.prescaler_index};
	assign fast_last = {1'b0, cfg.fast_range_last};
	assign slow_last = {1'b0, cfg.slow_range_last};
	assign is_pre    = (sw_idx == pre_idx);
	assign in_fast   = (sw_idx >= pre_idx + 9'd1) && (sw_idx <= fast_last);
	assign step_slow = wrap_q && (sw_idx >= fast_last + 9'd1) && (sw_idx <= slow_last);

	always_comb begin
		if (is_pre) begin
			if (wrap_q) begin
				// reload, then one slow step if the prescaler sits in the slow range
				new_val = step_slow ? PRESCALE_RELOAD - 8'd1 : PRESCALE_RELOAD;
			end else begin
				new_val = pre_q - 8'd1;
			end
		end else if ((step_slow || in_fast) && ram_rdata != 8'd0) begin
			new_val = ram_rdata - 8'd1;
		end else begin
			new_val = ram_rdata;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = 8'd0;
		ram_raddr = cnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (req.req_type == REQ_TICK) begin
					ram_raddr = AW'(cfg.prescaler_index);
				end else begin
					ram_raddr = AW'(req.entry_index);
				end
				if (accept && req.req_type == REQ_WRITE) begin
					ram_we    = req_in_store;
					ram_waddr = AW'(req.entry_index);
					ram_wdata = req.write_value;
				end
			end
			ST_RD, ST_PRE, ST_SWEEP, ST_DRAIN, ST_FIN: begin
			end
			default: begin
			end
		endcase
		// sweep write-back, in the cycle after its read
		if (vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wdata = new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_ENTRY) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							REQ_TICK:  state_q <= ST_PRE;
							REQ_READ:  state_q <= ST_RD;
							REQ_WRITE: state_q <= ST_FIN;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_RD:    state_q <= ST_FIN;
				ST_PRE: begin
					cnt_q   <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					vld_s1 <= 1'b1;
					if (cnt_q == SWEEP_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				in_store_q <= req_in_store;
				res_q      <= '0;
			end
			ST_RD: begin
				res_q.read_value        <= in_store_q ? ram_rdata : 8'd0;
				res_q.prescaler_wrapped <= 1'b0;
			end
			ST_PRE: begin
				pre_q  <= pre_val;
				wrap_q <= (pre_val == 8'd0);
			end
			ST_SWEEP: begin
				idx_s1 <= cnt_q;
			end
			ST_DRAIN: begin
				res_q.read_value        <= 8'd0;
				res_q.prescaler_wrapped <= wrap_q;
			end
			ST_CLEAR, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign done.valid = (state_q == ST_FIN);
	assign done.item  = res_q;

endmodule

### hdl/prescaled_countdown_timer_bank_core.sv
// ----------------------------------------------------------------------------
// prescaled_countdown_timer_bank_core
// Bank of byte countdown timers in one RAM, with a decade prescaler entry.
// ----------------------------------------------------------------------------
// After reset the block clears the timer RAM one entry per cycle before the
// first request is taken; configuration writes are accepted at any time. A
// write request passes from idle to the finish state, a read through a
// read-data state and then the finish state; the result shows up on rsp in
// the cycle the sequencer returns to idle. A tick reads the prescaler entry,
// then sweeps entries 0 to min(STORE_ENTRIES,256)-1 through the single RAM
// read port, one read-modify-write per cycle. One request is in work at a
// time; the result sits in an output register and the next request is
// accepted while it waits.
module prescaled_countdown_timer_bank_core import pctb_pkg::*; #(
	parameter int STORE_ENTRIES = STORE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_item_t  rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int AW = $clog2(STORE_ENTRIES);

	cfg_t          cfg_q;
	logic          rsp_valid_q;
	rsp_item_t     rsp_q;
	done_t         done;
	logic          out_free;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PRESCALER_INDEX: cfg_q.prescaler_index <= cfg_data;
				CFG_FAST_RANGE_LAST: cfg_q.fast_range_last <= cfg_data;
				CFG_SLOW_RANGE_LAST: cfg_q.slow_range_last <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output register: refills in the same cycle it drains
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done.valid && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid && out_free) begin
			rsp_q <= done.item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pctb_ctrl #(
		.STORE_ENTRIES(STORE_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.done      (done),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pctb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
